// ===== hw/rtl/ratio_fir_resampler_unit_defines.svh =====
// Assertion macros shared by the resampler checker.
`ifndef RATIO_FIR_RESAMPLER_UNIT_DEFINES_SVH
`define RATIO_FIR_RESAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define RFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define RFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rfr_pkg.sv =====
// Types and constants shared by the resampler modules.
package rfr_pkg;

    localparam int SMP_W   = 16;
    localparam int ACC_W   = 40;
    localparam int POS_W   = 48;
    localparam int FRAC_W  = 16;
    localparam int IPOS_W  = 32;
    localparam int STEP_W  = 24;
    localparam int CIDX_W  = 5;
    localparam int CNT_W   = 5;

    localparam logic [CNT_W-1:0]  MAX_OUT    = 5'd16;
    localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_COEF = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_CHECK,
        S_COEF,
        S_MSTART,
        S_MOD,
        S_TAPS,
        S_DRAIN,
        S_ADV,
        S_EMIT
    } t_state;

    // One ring entry as it moves along the chain.
    typedef struct packed {
        logic                    vld;
        logic signed [SMP_W-1:0] val;
    } t_smp;

    typedef struct packed {
        logic shift_s;
        logic shift_c;
    } t_chain_ctl;

endpackage

// ===== hw/rtl/ratio_fir_resampler_unit.sv =====
// Top level of the rational-ratio FIR resampler.
// A push rotates the sample chain until its write slot comes round. A coefficient
// write turns the coefficient chain once in full. Each output starts the
// reciprocal-multiply reduction of the tap position modulo TAPS, then the sample chain
// turns until its head holds the first tap and the single shared multiplier takes one
// tap per cycle, then the pipeline drains and the result is scaled. An output can also
// wait on the output side; when TAPS is not a power of two, a window across the 32-bit
// position wrap can add one more turn. One input gives at most 16 outputs; outputs
// still due wait for the next push. The sample ring reads as zero until written, with
// no clearing pass after reset.
module ratio_fir_resampler_unit #(
    parameter int TAPS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_opcode,
    input  logic signed [rfr_pkg::SMP_W-1:0] i_sample,
    input  logic [rfr_pkg::CIDX_W-1:0]       i_coef_index,
    input  logic signed [rfr_pkg::SMP_W-1:0] i_coef_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [rfr_pkg::SMP_W-1:0] o_out_sample,
    output logic                             o_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rfr_pkg::STEP_W-1:0]       i_step_ratio
);
    import rfr_pkg::*;

    localparam int SW = $clog2(TAPS);
    localparam int TW = $clog2(TAPS + 1);
    localparam int XW = (TW > CIDX_W) ? TW : CIDX_W;
    localparam logic [IPOS_W-1:0] HALF      = IPOS_W'(TAPS / 2);
    localparam logic [SW-1:0]     LAST_SLOT = SW'(TAPS - 1);
    localparam logic [TW-1:0]     LAST_TAP  = TW'(TAPS - 1);

    t_state                  r_state;
    t_state                  n_state;
    logic [STEP_W-1:0]       r_step;
    logic [IPOS_W-1:0]       r_sw;
    logic [SW-1:0]           r_wslot;
    logic [SW-1:0]           r_head;
    logic [POS_W-1:0]        r_pos;
    logic [CNT_W-1:0]        r_cnt;
    logic [TW-1:0]           r_tap;
    logic [IPOS_W-1:0]       r_n;
    logic [SW-1:0]           r_idx;
    logic signed [SMP_W-1:0] r_in_smp;
    logic [CIDX_W-1:0]       r_cidx;
    logic signed [SMP_W-1:0] r_cval;
    logic signed [SMP_W-1:0] r_res;
    logic                    r_out_vld;
    logic signed [SMP_W-1:0] r_out_smp;
    logic                    r_out_last;

    t_chain_ctl              w_ctl;
    t_smp                    w_s    [TAPS];
    t_smp                    w_s_in [TAPS];
    logic signed [SMP_W-1:0] w_c    [TAPS];
    logic signed [SMP_W-1:0] w_c_in [TAPS];
    t_smp                    w_tail_s;
    logic signed [SMP_W-1:0] w_tail_c;

    logic [IPOS_W-1:0]       w_ipos;
    logic [IPOS_W-1:0]       w_diff;
    logic [IPOS_W-1:0]       w_n0;
    logic                    w_ready;
    logic                    w_more;
    logic                    w_out_free;
    logic                    w_in_acc;
    logic                    w_match;
    logic                    w_wr_hit;
    logic                    w_coef_hit;
    logic                    w_tail_new;
    logic                    w_coef_new;
    logic                    w_tap_step;
    logic                    w_mod_start;
    logic                    w_mod_done;
    logic [SW-1:0]           w_mod_rem;
    logic                    w_mac_clr;
    logic                    w_mac_en;
    logic signed [SMP_W-1:0] w_mac_res;
    logic                    w_pos_adv;
    logic                    w_out_load;
    logic                    w_in_ready;

    // Readiness: samples_written - (ipos + TAPS/2) as a signed 32-bit difference.
    assign w_ipos     = r_pos[POS_W-1:FRAC_W];
    assign w_diff     = r_sw - w_ipos - HALF;
    assign w_ready    = !w_diff[IPOS_W-1];
    assign w_more     = w_ready && (r_cnt < MAX_OUT);
    assign w_n0       = w_ipos - HALF;
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_in_acc   = i_in_valid && w_in_ready;
    assign w_match    = (r_head == r_idx);
    assign w_wr_hit   = (r_head == r_wslot);
    assign w_coef_hit = (XW'(r_tap) == XW'(r_cidx));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_opcode == OP_COEF) ? S_COEF : S_WRITE;
                end
            end
            S_WRITE: begin
                if (w_wr_hit) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = w_ready ? S_MSTART : S_IDLE;
            end
            S_COEF: begin
                if (r_tap == LAST_TAP) begin
                    n_state = S_IDLE;
                end
            end
            S_MSTART: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_state = S_TAPS;
                end
            end
            S_TAPS: begin
                if (w_match && (r_tap == LAST_TAP)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_ADV;
            end
            S_ADV: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = w_more ? S_MSTART : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        w_in_ready    = 1'b0;
        w_ctl.shift_s = 1'b0;
        w_ctl.shift_c = 1'b0;
        w_tail_new    = 1'b0;
        w_coef_new    = 1'b0;
        w_tap_step    = 1'b0;
        w_mod_start   = 1'b0;
        w_mac_clr     = 1'b0;
        w_mac_en      = 1'b0;
        w_pos_adv     = 1'b0;
        w_out_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
            end
            S_WRITE: begin
                w_ctl.shift_s = 1'b1;
                w_tail_new    = w_wr_hit;
            end
            S_COEF: begin
                w_ctl.shift_c = 1'b1;
                w_coef_new    = w_coef_hit;
                w_tap_step    = 1'b1;
            end
            S_MSTART: begin
                w_mod_start = 1'b1;
                w_mac_clr   = 1'b1;
            end
            S_TAPS: begin
                // Keep turning the ring; take a tap only when the head holds it.
                w_ctl.shift_s = 1'b1;
                w_ctl.shift_c = w_match;
                w_mac_en      = w_match;
                w_tap_step    = w_match;
            end
            S_ADV: begin
                w_pos_adv = 1'b1;
            end
            S_EMIT: begin
                w_out_load = w_out_free;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // Tail of each chain takes the head back, or the new word at its slot.
    assign w_tail_s.vld = w_tail_new ? 1'b1 : w_s[0].vld;
    assign w_tail_s.val = w_tail_new ? r_in_smp : w_s[0].val;
    assign w_tail_c     = w_coef_new ? r_cval : w_c[0];

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        if (k == TAPS - 1) begin : g_tail
            assign w_s_in[k] = w_tail_s;
            assign w_c_in[k] = w_tail_c;
        end else begin : g_link
            assign w_s_in[k] = w_s[k+1];
            assign w_c_in[k] = w_c[k+1];
        end
        rfr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_s     (w_s_in[k]),
            .i_c     (w_c_in[k]),
            .o_s     (w_s[k]),
            .o_c     (w_c[k])
        );
    end

    rfr_mod #(
        .TAPS (TAPS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_value (w_n0),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    rfr_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (w_mac_clr),
        .i_en     (w_mac_en),
        .i_smp    (w_s[0].val),
        .i_coef   (w_c[0]),
        .o_result (w_mac_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= STEP_RESET;
            r_sw      <= '0;
            r_wslot   <= '0;
            r_head    <= '0;
            r_pos     <= '0;
            r_cnt     <= '0;
            r_tap     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_step <= i_step_ratio;
            end
            if (w_ctl.shift_s) begin
                r_head <= (r_head == LAST_SLOT) ? '0 : (r_head + SW'(1));
            end
            // The write slot restarts at zero when the sample count wraps.
            if (w_tail_new) begin
                r_sw <= r_sw + IPOS_W'(1);
                if (r_sw == '1) begin
                    r_wslot <= '0;
                end else begin
                    r_wslot <= (r_wslot == LAST_SLOT) ? '0 : (r_wslot + SW'(1));
                end
            end
            if (w_tap_step) begin
                r_tap <= (r_tap == LAST_TAP) ? '0 : (r_tap + TW'(1));
            end
            if (w_in_acc) begin
                r_cnt <= '0;
            end else if (w_pos_adv) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (w_pos_adv) begin
                r_pos <= r_pos + POS_W'(r_step);
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_smp <= i_sample;
            r_cidx   <= i_coef_index;
            r_cval   <= i_coef_value;
        end
        if (w_mod_start) begin
            r_n <= w_n0;
        end else if (w_mac_en) begin
            r_n <= r_n + IPOS_W'(1);
        end
        // The ring index jumps to zero where the 32-bit tap position wraps.
        if (w_mod_done) begin
            r_idx <= w_mod_rem;
        end else if (w_mac_en) begin
            if (r_n == '1) begin
                r_idx <= '0;
            end else begin
                r_idx <= (r_idx == LAST_SLOT) ? '0 : (r_idx + SW'(1));
            end
        end
        if (w_pos_adv) begin
            r_res <= w_mac_res;
        end
        if (w_out_load) begin
            r_out_smp  <= r_res;
            r_out_last <= !w_more;
        end
    end

    assign o_in_ready   = w_in_ready;
    assign o_out_valid  = r_out_vld;
    assign o_out_sample = r_out_smp;
    assign o_last       = r_out_last;
    assign o_cfg_ready  = 1'b1;

endmodule

// ===== hw/rtl/rfr_cell.sv =====
// One chain cell: a ring sample with its valid bit and one coefficient.
module rfr_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  rfr_pkg::t_chain_ctl                    i_ctl,
    input  rfr_pkg::t_smp                          i_s,
    input  logic signed [rfr_pkg::SMP_W-1:0]       i_c,
    output rfr_pkg::t_smp                          o_s,
    output logic signed [rfr_pkg::SMP_W-1:0]       o_c
);
    import rfr_pkg::*;

    logic                    r_vld;
    logic signed [SMP_W-1:0] r_val;
    logic signed [SMP_W-1:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.shift_s) begin
            r_vld <= i_s.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_s) begin
            r_val <= i_s.val;
        end
        if (i_ctl.shift_c) begin
            r_coef <= i_c;
        end
    end

    // An entry never written since reset reads as zero.
    assign o_s.vld = r_vld;
    assign o_s.val = r_vld ? r_val : '0;
    assign o_c     = r_coef;

endmodule

// ===== hw/rtl/rfr_mod.sv =====
// Reduction of a 32-bit tap position modulo TAPS by reciprocal multiplication.
module rfr_mod #(
    parameter int TAPS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rfr_pkg::IPOS_W-1:0]   i_value,
    output logic                         o_done,
    output logic [$clog2(TAPS)-1:0]      o_rem
);
    import rfr_pkg::*;

    localparam int SW     = $clog2(TAPS);
    localparam int PROD_W = 2 * IPOS_W + 1;
    localparam int QSH    = IPOS_W + SW;
    // floor(2^QSH / TAPS) + 1 gives the exact quotient for every 32-bit value.
    localparam logic [63:0]       RECIP64 = ((64'd1 << QSH) / 64'(TAPS)) + 64'd1;
    localparam logic [PROD_W-1:0] RECIP   = PROD_W'(RECIP64);
    localparam logic [IPOS_W-1:0] TAPS_V  = IPOS_W'(TAPS);

    logic [IPOS_W-1:0] r_val;
    logic [PROD_W-1:0] r_prod;
    logic [SW-1:0]     r_rem;
    logic              r_go;
    logic              r_prod_vld;
    logic              r_done;
    logic [IPOS_W-1:0] w_quo;
    logic [IPOS_W-1:0] w_back;
    logic [IPOS_W-1:0] w_diff;

    assign w_quo  = IPOS_W'(r_prod[PROD_W-1:QSH]);
    assign w_back = w_quo * TAPS_V;
    assign w_diff = r_val - w_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go       <= 1'b0;
            r_prod_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_go       <= i_start;
            r_prod_vld <= r_go;
            r_done     <= r_prod_vld;
        end
    end

    // Latch the value, multiply by the reciprocal, then subtract quotient times TAPS.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end
        if (r_go) begin
            r_prod <= PROD_W'(r_val) * RECIP;
        end
        if (r_prod_vld) begin
            r_rem <= w_diff[SW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/rfr_mac.sv =====
// Shared multiply-accumulate with truncating scale and 16-bit saturation.
module rfr_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clr,
    input  logic                               i_en,
    input  logic signed [rfr_pkg::SMP_W-1:0]   i_smp,
    input  logic signed [rfr_pkg::SMP_W-1:0]   i_coef,
    output logic signed [rfr_pkg::SMP_W-1:0]   o_result
);
    import rfr_pkg::*;

    localparam int PROD_W = 2 * SMP_W;
    localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_sum;
    logic signed [ACC_W-1:0]  w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_smp * i_coef;
        end
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Bias negative sums so the arithmetic shift truncates toward zero.
    assign w_sum = r_acc[ACC_W-1] ? (r_acc + BIAS) : r_acc;
    assign w_q   = w_sum >>> 15;

    always_comb begin
        if (w_q > SAT_MAX) begin
            o_result = SAT_MAX[SMP_W-1:0];
        end else if (w_q < SAT_MIN) begin
            o_result = SAT_MIN[SMP_W-1:0];
        end else begin
            o_result = w_q[SMP_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/rfr_checker.sv =====
// Port-level checks for the resampler, bound to the top level.
`include "ratio_fir_resampler_unit_defines.svh"

module rfr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             i_opcode,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic signed [rfr_pkg::SMP_W-1:0] o_out_sample,
    input logic                             o_last
);
    import rfr_pkg::*;

    logic             w_stall;
    logic             w_in_acc;
    logic             w_coef_idle;
    logic [SMP_W:0]   w_out_word;

    assign w_stall     = o_out_valid && !i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_coef_idle = w_in_acc && (i_opcode == OP_COEF) && !o_out_valid;
    assign w_out_word  = {o_out_sample, o_last};

    // Hold a stalled result word.
    `RFR_ASSERT_NEXT(a_out_hold, w_stall, o_out_valid && $stable(w_out_word), "held word changed")

    // A word that is not the last of its burst means the block is still busy.
    `RFR_ASSERT_NOW(a_burst_busy, o_out_valid && !o_last, !o_in_ready, "input ready mid-burst")

    // An accepted word keeps the block busy for at least the next cycle.
    `RFR_ASSERT_NEXT(a_accept_busy, w_in_acc, !o_in_ready, "input ready right after an accept")

    // A coefficient word accepted with no output pending produces no output.
    `RFR_ASSERT_NEXT(a_coef_silent, w_coef_idle, !o_out_valid, "coefficient word made an output")

endmodule

bind ratio_fir_resampler_unit rfr_checker u_rfr_checker (.*);
